// ----- rtl/core/ips_pkg.sv -----
`default_nettype none

package ips_pkg;

	// field and register widths
	localparam int unsigned STEP_W = 26;
	localparam int unsigned VOL_W  = 24;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned ACC_W  = 27;
	localparam int unsigned CFG_W  = 26;

	// register reset values
	localparam logic [STEP_W-1:0] STEP_RST   = 26'd0;
	localparam logic [VOL_W-1:0]  TARGET_RST = 24'd1000;
	localparam logic [CNT_W-1:0]  PRIME_RST  = 16'd100;
	localparam logic [TICK_W-1:0] TICK_RST   = 16'd200;

	// saturation limits
	localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// item kinds
	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_PRIMING   = 3'd1,
		ST_INFUSING  = 3'd2,
		ST_PAUSED    = 3'd3,
		ST_OCCLUSION = 3'd4,
		ST_COMPLETE  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		EV_START     = 3'd0,
		EV_STOP      = 3'd1,
		EV_PAUSE     = 3'd2,
		EV_RESUME    = 3'd3,
		EV_PRIMED    = 3'd4,
		EV_VOLUME    = 3'd5,
		EV_OCCLUSION = 3'd6,
		EV_CLEARED   = 3'd7
	} event_t;

	typedef enum logic [1:0] {
		CFG_STEP_INTERVAL = 2'd0,
		CFG_TARGET_VOLUME = 2'd1,
		CFG_PRIMING_TOTAL = 2'd2,
		CFG_TICK_PERIOD   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_interval;
		logic [VOL_W-1:0]  target_volume;
		logic [CNT_W-1:0]  priming_total;
		logic [TICK_W-1:0] tick_period;
	} cfg_t;

	typedef struct packed {
		logic             accepted;
		mode_t            pump_state;
		logic             step_pulse;
		logic             motor_enable;
		logic             occl_alarm;
		logic             complete_alarm;
		logic [VOL_W-1:0] delivered_volume;
	} res_t;

	typedef struct packed {
		logic  ok;
		mode_t next;
	} trans_t;

	// permitted transitions per state
	function automatic trans_t next_mode(mode_t from, event_t ev);
		trans_t t;
		t.ok   = 1'b1;
		t.next = from;
		case (from)
			ST_IDLE: begin
				if (ev == EV_START) t.next = ST_PRIMING;
				else t.ok = 1'b0;
			end
			ST_PRIMING: begin
				if (ev == EV_PRIMED) t.next = ST_INFUSING;
				else if (ev == EV_STOP) t.next = ST_IDLE;
				else t.ok = 1'b0;
			end
			ST_INFUSING: begin
				if (ev == EV_PAUSE) t.next = ST_PAUSED;
				else if (ev == EV_STOP) t.next = ST_IDLE;
				else if (ev == EV_VOLUME) t.next = ST_COMPLETE;
				else if (ev == EV_OCCLUSION) t.next = ST_OCCLUSION;
				else t.ok = 1'b0;
			end
			ST_PAUSED: begin
				if (ev == EV_RESUME) t.next = ST_INFUSING;
				else if (ev == EV_STOP) t.next = ST_IDLE;
				else t.ok = 1'b0;
			end
			ST_OCCLUSION: begin
				if (ev == EV_CLEARED) t.next = ST_PAUSED;
				else if (ev == EV_STOP) t.next = ST_IDLE;
				else t.ok = 1'b0;
			end
			ST_COMPLETE: begin
				if (ev == EV_STOP) t.next = ST_IDLE;
				else t.ok = 1'b0;
			end
			default: begin
				t.ok = 1'b0;
			end
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ips_ctrl.sv -----
`default_nettype none

module ips_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic             req_type,
	input  wire ips_pkg::event_t  event_code,
	input  wire ips_pkg::cfg_t    cfg,
	output ips_pkg::res_t         res
);
	import ips_pkg::*;

	mode_t              mode_q, mode_d;
	logic [CNT_W-1:0]   prime_cnt_q, prime_cnt_d;
	logic [ACC_W-1:0]   acc_q, acc_d;
	logic [VOL_W-1:0]   vol_q, vol_d;
	logic               motor_q, motor_d;
	logic               occ_q, occ_d;
	logic               cmpl_q, cmpl_d;

	trans_t             trans;
	logic               do_enter;
	mode_t              enter_mode;
	logic               accepted;
	logic               pulse;
	logic [ACC_W-1:0]   acc_sum;

	assign trans   = next_mode(mode_q, event_code);
	assign acc_sum = acc_q + ACC_W'(cfg.tick_period);

	// item update and entry actions
	always_comb begin
		mode_d      = mode_q;
		prime_cnt_d = prime_cnt_q;
		acc_d       = acc_q;
		vol_d       = vol_q;
		motor_d     = motor_q;
		occ_d       = occ_q;
		cmpl_d      = cmpl_q;
		do_enter    = 1'b0;
		enter_mode  = trans.next;
		accepted    = 1'b1;
		pulse       = 1'b0;

		if (req_type == REQ_EVENT) begin
			accepted = trans.ok;
			do_enter = trans.ok;
		end else if (mode_q == ST_PRIMING) begin
			pulse = 1'b1;
			if (prime_cnt_q != CNT_MAX) prime_cnt_d = prime_cnt_q + 1'b1;
			if (prime_cnt_d >= cfg.priming_total) begin
				do_enter   = 1'b1;
				enter_mode = ST_INFUSING;
			end
		end else if (mode_q == ST_INFUSING && cfg.step_interval != '0) begin
			acc_d = acc_sum;
			if (acc_sum >= ACC_W'(cfg.step_interval)) begin
				acc_d = '0;
				pulse = 1'b1;
				if (vol_q != VOL_MAX) vol_d = vol_q + 1'b1;
				if (vol_d >= cfg.target_volume) begin
					do_enter   = 1'b1;
					enter_mode = ST_COMPLETE;
				end
			end
		end

		if (do_enter) begin
			mode_d = enter_mode;
			case (enter_mode)
				ST_IDLE: begin
					motor_d     = 1'b0;
					vol_d       = '0;
					prime_cnt_d = '0;
					occ_d       = 1'b0;
					cmpl_d      = 1'b0;
				end
				ST_PRIMING: begin
					prime_cnt_d = '0;
					motor_d     = 1'b1;
				end
				ST_INFUSING: begin
					acc_d   = '0;
					motor_d = 1'b1;
				end
				ST_PAUSED: begin
					motor_d = 1'b0;
				end
				ST_OCCLUSION: begin
					motor_d = 1'b0;
					occ_d   = 1'b1;
				end
				default: begin
					motor_d = 1'b0;
					cmpl_d  = 1'b1;
				end
			endcase
		end
	end

	// result reports the state after the update
	always_comb begin
		res.accepted         = accepted;
		res.pump_state       = mode_d;
		res.step_pulse       = pulse;
		res.motor_enable     = motor_d;
		res.occl_alarm       = occ_d;
		res.complete_alarm   = cmpl_d;
		res.delivered_volume = vol_d;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ST_IDLE;
			prime_cnt_q <= '0;
			acc_q       <= '0;
			vol_q       <= '0;
			motor_q     <= 1'b0;
			occ_q       <= 1'b0;
			cmpl_q      <= 1'b0;
		end else if (go) begin
			mode_q      <= mode_d;
			prime_cnt_q <= prime_cnt_d;
			acc_q       <= acc_d;
			vol_q       <= vol_d;
			motor_q     <= motor_d;
			occ_q       <= occ_d;
			cmpl_q      <= cmpl_d;
		end
	end

`ifndef SYNTHESIS
	// motor runs only while priming or infusing
	a_motor_mode: assert property (@(posedge clk) disable iff (!arst_n)
		motor_q == (mode_q == ST_PRIMING || mode_q == ST_INFUSING))
		else $error("motor enable does not match pump mode");

	// complete flag is only ever seen in the complete state
	a_cmpl_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmpl_q |-> mode_q == ST_COMPLETE)
		else $error("complete flag outside complete state");

	// idle holds no volume and no alarms
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ST_IDLE |-> vol_q == '0 && !occ_q && !cmpl_q)
		else $error("idle with volume or alarm left over");

	// occlusion state always carries its flag
	a_occ_flag: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ST_OCCLUSION |-> occ_q)
		else $error("occlusion state without occlusion flag");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/infusion_pump_sequencer.sv -----
// channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------------------------
// in      | into      | in_valid / in_stall | req_type, event_code
// out     | out of    | out_valid/out_stall | accepted, pump_state, step_pulse,
//         |           |                     | motor_enable, occl_alarm,
//         |           |                     | complete_alarm, delivered_volume
// cfg     | into      | cfg_we              | cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; a beat is held in the input
// register and its result is loaded into the output register when it can advance, which
// raises out_valid. The throughput is set by the state update between those two
// registers.
// Reset clears the pump state, both valid flags and loads the register defaults.
// A stalled output holds; in_stall is raised only while the input register holds
// a beat that cannot move on because the output register is full and stalled.
`default_nettype none

module infusion_pump_sequencer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      req_type,
	input  wire logic [2:0]                event_code,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           accepted,
	output logic [2:0]                     pump_state,
	output logic                           step_pulse,
	output logic                           motor_enable,
	output logic                           occl_alarm,
	output logic                           complete_alarm,
	output logic [ips_pkg::VOL_W-1:0]      delivered_volume,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [ips_pkg::CFG_W-1:0] cfg_data
);
	import ips_pkg::*;

	cfg_t   cfg_q;
	logic   valid_s1;
	logic   req_type_s1;
	event_t event_code_s1;
	logic   out_valid_q;
	res_t   res_q;
	res_t   res;
	logic   advance;
	logic   go;
	logic   in_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_interval <= STEP_RST;
			cfg_q.target_volume <= TARGET_RST;
			cfg_q.priming_total <= PRIME_RST;
			cfg_q.tick_period   <= TICK_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STEP_INTERVAL: cfg_q.step_interval <= cfg_data[STEP_W-1:0];
				CFG_TARGET_VOLUME: cfg_q.target_volume <= cfg_data[VOL_W-1:0];
				CFG_PRIMING_TOTAL: cfg_q.priming_total <= cfg_data[CNT_W-1:0];
				CFG_TICK_PERIOD:   cfg_q.tick_period   <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// flow control
	assign advance  = !out_valid_q || !out_stall;
	assign go       = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_type_s1   <= req_type;
			event_code_s1 <= event_t'(event_code);
		end
	end

	ips_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.req_type   (req_type_s1),
		.event_code (event_code_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = res_q.accepted;
	assign pump_state       = res_q.pump_state;
	assign step_pulse       = res_q.step_pulse;
	assign motor_enable     = res_q.motor_enable;
	assign occl_alarm       = res_q.occl_alarm;
	assign complete_alarm   = res_q.complete_alarm;
	assign delivered_volume = res_q.delivered_volume;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import ips_pkg::*;

	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_ITEMS  = 190;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	// predicts every result beat of the sequencer and checks the beats that come out
	class pump_scoreboard;
		logic [STEP_W-1:0] step_ivl;
		logic [VOL_W-1:0]  target_vol;
		logic [CNT_W-1:0]  prime_total;
		logic [TICK_W-1:0] tick_us;
		mode_t             pump_mode;
		logic [CNT_W-1:0]  prime_cnt;
		logic [ACC_W-1:0]  elapsed_us;
		logic [VOL_W-1:0]  volume_ul;
		logic              motor_on;
		logic              occ_flag;
		logic              done_flag;
		res_t              expected_beats[$];
		int                errors;

		function new();
			step_ivl    = STEP_RST;
			target_vol  = TARGET_RST;
			prime_total = PRIME_RST;
			tick_us     = TICK_RST;
			pump_mode   = ST_IDLE;
			prime_cnt   = '0;
			elapsed_us  = '0;
			volume_ul   = '0;
			motor_on    = 1'b0;
			occ_flag    = 1'b0;
			done_flag   = 1'b0;
			errors      = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_STEP_INTERVAL: step_ivl    = data[STEP_W-1:0];
				CFG_TARGET_VOLUME: target_vol  = data[VOL_W-1:0];
				CFG_PRIMING_TOTAL: prime_total = data[CNT_W-1:0];
				default:           tick_us     = data[TICK_W-1:0];
			endcase
		endfunction

		// no state moves to itself, so a changed mode means the event is permitted
		function bit lookup(mode_t from, event_t ev, output mode_t to);
			to = from;
			case (from)
				ST_IDLE: begin
					if (ev == EV_START) to = ST_PRIMING;
				end
				ST_PRIMING: begin
					if (ev == EV_PRIMED) to = ST_INFUSING;
					else if (ev == EV_STOP) to = ST_IDLE;
				end
				ST_INFUSING: begin
					case (ev)
						EV_PAUSE:     to = ST_PAUSED;
						EV_STOP:      to = ST_IDLE;
						EV_VOLUME:    to = ST_COMPLETE;
						EV_OCCLUSION: to = ST_OCCLUSION;
						default:      to = from;
					endcase
				end
				ST_PAUSED: begin
					if (ev == EV_RESUME) to = ST_INFUSING;
					else if (ev == EV_STOP) to = ST_IDLE;
				end
				ST_OCCLUSION: begin
					if (ev == EV_CLEARED) to = ST_PAUSED;
					else if (ev == EV_STOP) to = ST_IDLE;
				end
				default: begin
					if (ev == EV_STOP) to = ST_IDLE;
				end
			endcase
			return to != from;
		endfunction

		// entry actions of each state
		function void enter_mode(mode_t m);
			pump_mode = m;
			case (m)
				ST_IDLE: begin
					motor_on  = 1'b0;
					volume_ul = '0;
					prime_cnt = '0;
					occ_flag  = 1'b0;
					done_flag = 1'b0;
				end
				ST_PRIMING: begin
					prime_cnt = '0;
					motor_on  = 1'b1;
				end
				ST_INFUSING: begin
					elapsed_us = '0;
					motor_on   = 1'b1;
				end
				ST_PAUSED: motor_on = 1'b0;
				ST_OCCLUSION: begin
					motor_on = 1'b0;
					occ_flag = 1'b1;
				end
				default: begin
					motor_on  = 1'b0;
					done_flag = 1'b1;
				end
			endcase
		endfunction

		function void note_request(logic kind, logic [2:0] code);
			res_t  want;
			mode_t nxt;
			logic  ok;
			logic  pulse;
			ok    = 1'b1;
			pulse = 1'b0;
			if (kind == REQ_EVENT) begin
				if (lookup(pump_mode, event_t'(code), nxt)) enter_mode(nxt);
				else ok = 1'b0;
			end else if (pump_mode == ST_PRIMING) begin
				pulse = 1'b1;
				if (prime_cnt != CNT_MAX) prime_cnt++;
				if (prime_cnt >= prime_total) enter_mode(ST_INFUSING);
			end else if (pump_mode == ST_INFUSING && step_ivl != '0) begin
				elapsed_us = elapsed_us + tick_us;
				if (elapsed_us >= step_ivl) begin
					elapsed_us = '0;
					pulse      = 1'b1;
					if (volume_ul != VOL_MAX) volume_ul++;
					if (volume_ul >= target_vol) enter_mode(ST_COMPLETE);
				end
			end
			want.accepted         = ok;
			want.pump_state       = pump_mode;
			want.step_pulse       = pulse;
			want.motor_enable     = motor_on;
			want.occl_alarm       = occ_flag;
			want.complete_alarm   = done_flag;
			want.delivered_volume = volume_ul;
			expected_beats.push_back(want);
		endfunction

		function void mismatch(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		endfunction

		function void check_beat(res_t got);
			res_t want;
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, state %0h",
					$time, got.pump_state);
				return;
			end
			want = expected_beats.pop_front();
			if (got.accepted !== want.accepted)
				mismatch("accepted", want.accepted, got.accepted);
			if (got.pump_state !== want.pump_state)
				mismatch("pump_state", want.pump_state, got.pump_state);
			if (got.step_pulse !== want.step_pulse)
				mismatch("step_pulse", want.step_pulse, got.step_pulse);
			if (got.motor_enable !== want.motor_enable)
				mismatch("motor_enable", want.motor_enable, got.motor_enable);
			if (got.occl_alarm !== want.occl_alarm)
				mismatch("occl_alarm", want.occl_alarm, got.occl_alarm);
			if (got.complete_alarm !== want.complete_alarm)
				mismatch("complete_alarm", want.complete_alarm, got.complete_alarm);
			if (got.delivered_volume !== want.delivered_volume)
				mismatch("delivered_volume", want.delivered_volume, got.delivered_volume);
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               req_type;
	logic [2:0]         event_code;
	logic               out_valid;
	logic               out_stall;
	logic               accepted;
	logic [2:0]         pump_state;
	logic               step_pulse;
	logic               motor_enable;
	logic               occl_alarm;
	logic               complete_alarm;
	logic [VOL_W-1:0]   delivered_volume;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	pump_scoreboard     sb;
	bit                 quiet = 1'b0;
	int unsigned        sink_hold = 0;

	infusion_pump_sequencer DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.event_code       (event_code),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.accepted         (accepted),
		.pump_state       (pump_state),
		.step_pulse       (step_pulse),
		.motor_enable     (motor_enable),
		.occl_alarm       (occl_alarm),
		.complete_alarm   (complete_alarm),
		.delivered_volume (delivered_volume),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #2 clk = ~clk;

	// offer one beat after a random gap and hold it until taken
	task automatic send_item(input logic kind, input logic [2:0] code);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		event_code <= code;
		do @(posedge clk); while (in_stall);
		sb.note_request(kind, code);
	endtask

	task automatic tick();
		send_item(REQ_TICK, 3'($urandom_range(0, 7)));
	endtask

	task automatic ev(input event_t e);
		send_item(REQ_EVENT, e);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// junk above each narrow register's width must be dropped by the block
	task automatic program_regs(input logic [STEP_W-1:0] step_v,
		input logic [VOL_W-1:0] vol_v, input logic [CNT_W-1:0] prime_v,
		input logic [TICK_W-1:0] tick_v);
		write_reg(CFG_STEP_INTERVAL, CFG_W'(step_v));
		write_reg(CFG_TARGET_VOLUME, CFG_W'(vol_v) | (CFG_W'($urandom) << VOL_W));
		write_reg(CFG_PRIMING_TOTAL, CFG_W'(prime_v) | (CFG_W'($urandom) << CNT_W));
		write_reg(CFG_TICK_PERIOD, CFG_W'(tick_v) | (CFG_W'($urandom) << TICK_W));
		cfg_we <= 1'b0;
	endtask

	// mostly ticks and events the current state permits, some random noise
	task automatic next_item(output logic kind, output logic [2:0] code);
		int unsigned roll;
		int unsigned pick;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 7);
		kind = REQ_EVENT;
		code = 3'($urandom_range(0, 7));
		if (roll < 55) begin
			kind = REQ_TICK;
		end else if (roll < 90) begin
			case (sb.pump_mode)
				ST_IDLE:      code = EV_START;
				ST_PRIMING:   code = (pick < 2) ? EV_STOP : EV_PRIMED;
				ST_INFUSING: begin
					case (pick)
						0:       code = EV_STOP;
						1, 2:    code = EV_PAUSE;
						3, 4:    code = EV_OCCLUSION;
						5:       code = EV_VOLUME;
						default: kind = REQ_TICK;
					endcase
				end
				ST_PAUSED:    code = (pick < 2) ? EV_STOP : EV_RESUME;
				ST_OCCLUSION: code = (pick < 2) ? EV_STOP : EV_CLEARED;
				default:      code = EV_STOP;
			endcase
		end
	endtask

	// result side: random stall per beat, plus one long hold-off on request
	initial begin : result_sink
		int unsigned gap;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 3);
			if (sink_hold != 0) begin
				gap       = sink_hold;
				sink_hold = 0;
			end
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// every beat taken on the result side goes to the scoreboard
	always @(posedge clk) begin : result_monitor
		res_t beat;
		if (arst_n && out_valid && !out_stall) begin
			beat.accepted         = accepted;
			beat.pump_state       = mode_t'(pump_state);
			beat.step_pulse       = step_pulse;
			beat.motor_enable     = motor_enable;
			beat.occl_alarm       = occl_alarm;
			beat.complete_alarm   = complete_alarm;
			beat.delivered_volume = delivered_volume;
			sb.check_beat(beat);
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** infusion_pump_sequencer: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic        kind;
		logic [2:0]  code;
		int unsigned tick_v;
		int unsigned step_v;
		sb = new();
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		req_type   <= REQ_EVENT;
		event_code <= EV_START;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_STEP_INTERVAL;
		cfg_data   <= '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: step interval zero, so infusing ticks do nothing
		tick();
		ev(EV_STOP);
		ev(EV_CLEARED);
		ev(EV_START);
		ev(EV_START);
		tick();
		ev(EV_PRIMED);
		tick();
		// occlusion flag survives the way back through paused and infusing
		ev(EV_OCCLUSION);
		tick();
		ev(EV_RESUME);
		ev(EV_CLEARED);
		tick();
		ev(EV_RESUME);
		ev(EV_PAUSE);
		ev(EV_STOP);
		ev(EV_START);
		ev(EV_STOP);
		// completion by event, then rejected and idle events
		ev(EV_START);
		ev(EV_PRIMED);
		ev(EV_VOLUME);
		tick();
		ev(EV_PAUSE);
		ev(EV_STOP);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				// zero priming total and zero target: first tick primes, first step completes
				program_regs(26'd1, '0, '0, 16'd1);
			end else if (p == 1) begin
				program_regs(26'd60000000, VOL_MAX, CNT_MAX, {TICK_W{1'b1}});
			end else begin
				tick_v = $urandom_range(1, 65535);
				if ($urandom_range(0, 3) == 0)
					step_v = $urandom_range(1, 60000000);
				else
					step_v = tick_v * $urandom_range(1, 4) - $urandom_range(0, tick_v - 1);
				program_regs(STEP_W'(step_v), VOL_W'($urandom_range(0, 8)),
					CNT_W'($urandom_range(0, 6)), TICK_W'(tick_v));
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// back-to-back stretches; one phase also holds the output off for long
				quiet = (i >= 120 && i < 150) || (p == 2 && i >= 40 && i < 70);
				if (p == 2 && i == 40) sink_hold = 60;
				next_item(kind, code);
				send_item(kind, code);
			end
			quiet = 1'b0;
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d results never arrived", $time, sb.pending());
		end
		if (sb.errors == 0)
			$display("** infusion_pump_sequencer: PASSED **");
		else
			$display("** infusion_pump_sequencer: FAILED **");
		$finish;
	end

endmodule
